[rtl/stack_alu_multiwidth_defines.svh]
// Assertion macros for the stack arithmetic block
`ifndef STACK_ALU_MULTIWIDTH_DEFINES_SVH
`define STACK_ALU_MULTIWIDTH_DEFINES_SVH
// implication checked on every edge out of reset
`define SAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SAM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/sam_pkg.sv]
// ----------------------------------------------------------------------------
// sam_pkg
// Types and constants for the stack arithmetic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sam_pkg;
  localparam int unsigned StackDepthDef = 16;

  localparam logic [1:0] ReqPush = 2'd0;
  localparam logic [1:0] ReqPop  = 2'd1;
  localparam logic [1:0] ReqArith = 2'd2;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StOver  = 2'd2;
  localparam logic [1:0] StDivz  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         op_code;
    logic [1:0]         operand_size;
    logic signed [63:0] push_value;
  } sam_in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
    logic [4:0]         depth_after;
  } sam_out_t;

  // sign extension from 8/16/32/64 bits
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] sz);
    logic [63:0] r;
    case (sz)
      2'd0: r = {{56{v[7]}}, v[7:0]};
      2'd1: r = {{48{v[15]}}, v[15:0]};
      2'd2: r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction
endpackage

[rtl/stack_alu_multiwidth.sv]
// ----------------------------------------------------------------------------
// stack_alu_multiwidth
// Data stack in RAM with add, subtract, multiply and divide on the top two.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o / in_data_i) carries one request beat:
//   push, pop or arithmetic on the top two entries. out channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one beat per
//   request with the value, a status code and the depth afterwards.
//   One request is worked at a time. Push and error beats are answered from
//   SIdle. Pop passes SPopW and SOut (one RAM read). Add/sub pass SRdA,
//   SGetA, SExec, SMul and SFin (two RAM reads). Multiply forms the low 64 bits
//   of a 64x64 product from three 32x32 partial products in SMul. Divide
//   runs a restoring divider in SDiv that retires one quotient bit per cycle
//   (divide by zero ends in SMul).
//   Reset clears the depth counter and the control state; stack RAM contents
//   are undefined but never read before written. While a result beat is
//   pending and out_stall_i is high, the beat holds and no new request is taken.
`timescale 1ns / 1ps
module stack_alu_multiwidth
  import sam_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sam_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sam_out_t out_data_o
);
`include "stack_alu_multiwidth_defines.svh"
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  localparam logic [3:0] SIdle = 4'd0, SRdB = 4'd1, SRdA = 4'd2, SGetA = 4'd3,
                         SExec = 4'd4, SMul = 4'd5, SDiv = 4'd6, SFin = 4'd7,
                         SOut = 4'd8, SPopW = 4'd9;

  logic [3:0]  st_q;
  logic [CW-1:0] cnt_q;
  sam_in_t     req_q;
  logic [63:0] a_q, b_q, r_q;
  logic [2:0]  mstep_q;
  logic [6:0]  dstep_q;
  logic [63:0] rem_q, quo_q;
  logic        neg_q;
  sam_out_t    out_q;
  logic        ovalid_q;
  logic        out_load;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  sam_ram #(.Width(64), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = (st_q != SIdle) || (ovalid_q && out_stall_i);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
  wire take = in_valid_i && !in_stall_o;

  // a result beat is loaded this edge
  assign out_load = (take && !(in_data_i.req_type == ReqPop && cnt_q != '0)
                          && !(in_data_i.req_type == ReqArith && cnt_q >= CW'(2)))
                    || (st_q == SOut) || (st_q == SFin)
                    || (st_q == SMul && req_q.op_code == OpDiv && b_q == '0);

  // read address: top, then second
  always_comb begin
    raddr = AW'(cnt_q - CW'(1));
    if (st_q == SRdA) raddr = AW'(cnt_q - CW'(2));
  end

  // final value, wrapped at 32 bits for 32-bit operands
  logic [63:0] fin;
  always_comb begin
    fin = r_q;
    if (req_q.operand_size == 2'd2) fin = sext(r_q, 2'd2);
  end

  // RAM write port
  always_comb begin
    we = 1'b0;
    waddr = AW'(cnt_q);
    wdata = in_data_i.push_value;
    if (take && in_data_i.req_type == ReqPush && cnt_q < CW'(StackDepth)) we = 1'b1;
    if (st_q == SFin) begin
      we = 1'b1;
      waddr = AW'(cnt_q - CW'(2));
      wdata = fin;
    end
  end

  // partial products of the multiply
  logic [63:0] pp;
  always_comb begin
    case (mstep_q[1:0])
      2'd0: pp = a_q[31:0] * b_q[31:0];
      2'd1: pp = a_q[63:32] * b_q[31:0];
      2'd2: pp = a_q[31:0] * b_q[63:32];
      default: pp = 64'd0;
    endcase
  end

  // one restoring divide step
  logic [64:0] dtry;
  logic [63:0] rsh;
  assign rsh  = {rem_q[62:0], quo_q[63]};
  assign dtry = {1'b0, rsh} - {1'b0, b_q};

  // result valid: set on a new result beat, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cnt_q <= '0;
    end else begin
      case (st_q)
        SIdle: begin
          if (take) begin
            req_q <= in_data_i;
            case (in_data_i.req_type)
              ReqPush: begin
                out_q.result_value <= '0;
                if (cnt_q >= CW'(StackDepth)) begin
                  out_q.status <= StOver;
                  out_q.depth_after <= 5'(cnt_q);
                end else begin
                  out_q.status <= StOk;
                  out_q.depth_after <= 5'(cnt_q + CW'(1));
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              ReqPop: begin
                if (cnt_q == '0) begin
                  out_q <= '{result_value: '0, status: StUnder, depth_after: 5'(cnt_q)};
                end else st_q <= SPopW;
              end
              ReqArith: begin
                if (cnt_q < CW'(2)) begin
                  out_q <= '{result_value: '0, status: StUnder, depth_after: 5'(cnt_q)};
                end else st_q <= SRdA;
              end
              default: begin
                out_q <= '{result_value: '0, status: StOk, depth_after: 5'(cnt_q)};
              end
            endcase
          end
        end
        SPopW: begin
          // read of top issued in SIdle->SPopW, data lands next
          st_q <= SOut;
        end
        SOut: begin
          out_q <= '{result_value: rdata, status: StOk, depth_after: 5'(cnt_q - CW'(1))};
          cnt_q <= cnt_q - CW'(1);
          st_q <= SIdle;
        end
        SRdA: begin
          st_q <= SGetA;
        end
        SGetA: begin
          // second entry read in SRdA
          a_q <= sext(rdata, req_q.operand_size);
          st_q <= SExec;
        end
        SExec: begin
          // top entry read in SGetA
          b_q <= sext(rdata, req_q.operand_size);
          mstep_q <= '0;
          st_q <= SMul;
        end
        SMul: begin
          case (req_q.op_code)
            OpAdd: begin r_q <= a_q + b_q; st_q <= SFin; end
            OpSub: begin r_q <= a_q - b_q; st_q <= SFin; end
            OpMul: begin
              mstep_q <= mstep_q + 3'd1;
              case (mstep_q)
                3'd0: r_q <= pp;
                3'd1: r_q <= r_q + {pp[31:0], 32'd0};
                3'd2: begin r_q <= r_q + {pp[31:0], 32'd0}; st_q <= SFin; end
                default: st_q <= SFin;
              endcase
            end
            default: begin
              if (b_q == '0) begin
                out_q <= '{result_value: '0, status: StDivz, depth_after: 5'(cnt_q)};
                st_q <= SIdle;
              end else begin
                neg_q <= a_q[63] ^ b_q[63];
                quo_q <= a_q[63] ? -a_q : a_q;
                b_q <= b_q[63] ? -b_q : b_q;
                rem_q <= '0;
                dstep_q <= '0;
                st_q <= SDiv;
              end
            end
          endcase
        end
        SDiv: begin
          if (!dtry[64]) rem_q <= dtry[63:0];
          else rem_q <= rsh;
          quo_q <= {quo_q[62:0], !dtry[64]};
          dstep_q <= dstep_q + 7'd1;
          if (dstep_q == 7'd63) begin
            r_q <= neg_q ? -{quo_q[62:0], !dtry[64]} : {quo_q[62:0], !dtry[64]};
            st_q <= SFin;
          end
        end
        SFin: begin
          out_q <= '{result_value: fin, status: StOk, depth_after: 5'(cnt_q - CW'(1))};
          cnt_q <= cnt_q - CW'(1);
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `SAM_ASSERT_IMP(a_depth, cnt_q > CW'(StackDepth), 1'b0)
  `SAM_ASSERT_NXT(a_busy, take, out_valid_o || st_q != SIdle)
  `SAM_ASSERT_NXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `SAM_ASSERT_NXT(a_fin, st_q == SFin, out_valid_o && st_q == SIdle)
endmodule

[rtl/sam_ram.sv]
// ----------------------------------------------------------------------------
// sam_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sam_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
